// ----- hdl/apcd_pkg.sv -----
// Shared types and constants for the address phase change detector.
package apcd_pkg;

  localparam int ADDR_WIDTH = 48;
  localparam int THR_WIDTH  = 32;
  localparam int HITS_WIDTH = 32;
  localparam int TUNE_WIDTH = 16;
  localparam int IDX_WIDTH  = 2;

  localparam int IN_TDATA_WIDTH  = 48;
  localparam int OUT_TDATA_WIDTH = 56;

  // Detector modes
  localparam logic [1:0] MODE_STABLE   = 2'd0;
  localparam logic [1:0] MODE_FIRST    = 2'd1;
  localparam logic [1:0] MODE_RECHANGE = 2'd2;
  localparam logic [1:0] MODE_TUNING   = 2'd3;

  // Configuration register indexes
  localparam logic [IDX_WIDTH-1:0] REG_DIST_THR = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_HOLD_THR = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_TUNE_LEN = 2'd2;

  localparam logic [THR_WIDTH-1:0]  DIST_THR_RESET = 32'd1024;
  localparam logic [THR_WIDTH-1:0]  HOLD_THR_RESET = 32'd128;
  localparam logic [TUNE_WIDTH-1:0] TUNE_LEN_RESET = 16'd512;

  typedef struct packed {
    logic [THR_WIDTH-1:0]  dist_thr;
    logic [THR_WIDTH-1:0]  hold_thr;
    logic [TUNE_WIDTH-1:0] tune_len;
  } apcd_cfg_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] current_base;
    logic [1:0]            detector_mode;
    logic                  phase_changed;
  } apcd_result_t;

endpackage

// ----- hdl/address_phase_change_detector_unit.sv -----
// Top level of the address phase change detector: stream ports, config and pipeline.
//
//  channel | direction | handshake           | content
//  in_     | slave     | in_tvalid/in_tready | tdata: access_address[47:0]
//  out_    | master    | out_tvalid/out_tready | tdata: phase_changed, detector_mode, current_base
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request per clock is taken unless a stalled output backs up; each request passes
// the input register, then the apcd_core state update and the result register.
// Reset (rst_n low, synchronous) restores register defaults and empties both stages.
// A stalled output holds its result; the input register keeps its request until the
// output register frees up, so in_tready drops only when both stages are full.
// cfg_ready is always high.
module address_phase_change_detector_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [47:0] access_address
  input  logic [apcd_pkg::IN_TDATA_WIDTH-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // [0] phase_changed, [2:1] detector_mode, [50:3] current_base, [55:51] zero
  output logic [apcd_pkg::OUT_TDATA_WIDTH-1:0]   out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [apcd_pkg::IDX_WIDTH-1:0]         cfg_index,
  input  logic [apcd_pkg::THR_WIDTH-1:0]         cfg_data
);
  import apcd_pkg::*;

  apcd_cfg_t             cfg_r;
  logic                  s1_valid_r;
  logic [ADDR_WIDTH-1:0] s1_addr_r;
  logic                  out_valid_r;
  apcd_result_t          out_res_r;
  apcd_result_t          res;
  logic                  advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dist_thr <= DIST_THR_RESET;
      cfg_r.hold_thr <= HOLD_THR_RESET;
      cfg_r.tune_len <= TUNE_LEN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIST_THR: cfg_r.dist_thr <= cfg_data;
        REG_HOLD_THR: cfg_r.hold_thr <= cfg_data;
        REG_TUNE_LEN: cfg_r.tune_len <= cfg_data[TUNE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_addr_r <= in_tdata[ADDR_WIDTH-1:0];
  end

  apcd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (advance),
    .addr_i (s1_addr_r),
    .cfg_i  (cfg_r),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_WIDTH-ADDR_WIDTH-3){1'b0}}, out_res_r};

endmodule

// ----- hdl/apcd_core.sv -----
// Tracking state and per-access update of the phase change detector.
module apcd_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_i,
  input  logic [apcd_pkg::ADDR_WIDTH-1:0] addr_i,
  input  apcd_pkg::apcd_cfg_t            cfg_i,
  output apcd_pkg::apcd_result_t         res_o
);
  import apcd_pkg::*;

  logic [1:0]            mode_r, mode_nxt;
  logic [ADDR_WIDTH-1:0] base_r, base_nxt;
  logic [HITS_WIDTH-1:0] hits_r, hits_nxt;
  logic [ADDR_WIDTH-1:0] sbase_r, sbase_nxt;
  logic [HITS_WIDTH-1:0] shits_r, shits_nxt;
  logic [TUNE_WIDTH-1:0] tune_r, tune_nxt;
  logic                  pulse;

  logic [ADDR_WIDTH-1:0] base_gap, sdist, thr_ext;
  logic                  far, near_saved;
  logic [HITS_WIDTH-1:0] hits_inc;

  assign thr_ext    = {{(ADDR_WIDTH-THR_WIDTH){1'b0}}, cfg_i.dist_thr};
  assign base_gap   = (base_r >= addr_i) ? (base_r - addr_i) : (addr_i - base_r);
  assign sdist      = (sbase_r >= addr_i) ? (sbase_r - addr_i) : (addr_i - sbase_r);
  assign far        = base_gap > thr_ext;
  assign near_saved = sdist < thr_ext;
  assign hits_inc   = (&hits_r) ? hits_r : hits_r + 1'b1;

  always_comb begin
    mode_nxt  = mode_r;
    base_nxt  = base_r;
    hits_nxt  = hits_r;
    sbase_nxt = sbase_r;
    shits_nxt = shits_r;
    tune_nxt  = tune_r;
    pulse     = 1'b0;
    if (base_r == '0) begin
      // no base yet: the access only becomes the base
      base_nxt = addr_i;
    end else begin
      unique case (mode_r)
        MODE_STABLE: begin
          if (far) begin
            sbase_nxt = base_r;
            shits_nxt = hits_r;
            mode_nxt  = MODE_FIRST;
            base_nxt  = addr_i;
            hits_nxt  = '0;
          end else begin
            hits_nxt = hits_inc;
          end
        end
        MODE_FIRST, MODE_RECHANGE: begin
          if (far) begin
            if (mode_r == MODE_FIRST) begin
              mode_nxt = MODE_RECHANGE;
              base_nxt = addr_i;
              hits_nxt = '0;
            end else if (near_saved) begin
              base_nxt = sbase_r;
              hits_nxt = shits_r;
              mode_nxt = MODE_STABLE;
            end else begin
              base_nxt = addr_i;
              hits_nxt = '0;
            end
          end else begin
            hits_nxt = hits_inc;
            if (hits_inc > cfg_i.hold_thr) mode_nxt = MODE_TUNING;
          end
        end
        default: begin
          if (tune_r >= cfg_i.tune_len) begin
            tune_nxt = '0;
            mode_nxt = MODE_STABLE;
            pulse    = 1'b1;
          end else begin
            tune_nxt = tune_r + 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_FIRST;
      base_r  <= '0;
      hits_r  <= '0;
      sbase_r <= '0;
      shits_r <= '0;
      tune_r  <= '0;
    end else if (step_i) begin
      mode_r  <= mode_nxt;
      base_r  <= base_nxt;
      hits_r  <= hits_nxt;
      sbase_r <= sbase_nxt;
      shits_r <= shits_nxt;
      tune_r  <= tune_nxt;
    end
  end

  assign res_o.phase_changed = pulse;
  assign res_o.detector_mode = mode_nxt;
  assign res_o.current_base  = base_nxt;

  a_pulse_ends_tuning: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && pulse |=> mode_r == MODE_STABLE && tune_r == '0)
    else $error("phase change pulse did not return to stable");

  a_no_base_keeps_mode: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && base_r == '0 |=> mode_r == $past(mode_r) && hits_r == $past(hits_r))
    else $error("mode or hits changed while no base was set");

  a_stable_near_keeps_base: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && base_r != '0 && mode_r == MODE_STABLE && !far |=> base_r == $past(base_r))
    else $error("base moved on a near access in stable mode");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step_i |=> $stable(mode_r) && $stable(base_r) && $stable(tune_r))
    else $error("state changed without an access");

  a_pulse_only_from_tuning: assert property (@(posedge clk) disable iff (!rst_n)
    pulse |-> mode_r == MODE_TUNING && base_r != '0)
    else $error("phase change pulse outside tuning");

endmodule
